// ----- hw/rtl/gcbb_pkg.sv -----
package gcbb_pkg;

	localparam int COORD_W  = 12;
	localparam int BYTE_W   = 8;
	localparam int BOX_W    = 4 * BYTE_W;
	localparam int RAM_W    = BOX_W + 1;
	localparam int CFG_IDX_W = 3;

	localparam logic [3:0] LOG2_MAX = 4'd8;

	localparam logic [7:0] RST_ALPHA_THRESHOLD  = 8'd50;
	localparam logic [3:0] RST_CELL_WIDTH_LOG2  = 4'd4;
	localparam logic [3:0] RST_CELL_HEIGHT_LOG2 = 4'd4;
	localparam logic [4:0] RST_GRID_COLUMNS     = 5'd16;
	localparam logic [4:0] RST_GRID_ROWS        = 5'd16;
	localparam logic [7:0] RST_LINE_HEIGHT      = 8'd0;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHA_THRESHOLD,
		CFG_CELL_WIDTH_LOG2,
		CFG_CELL_HEIGHT_LOG2,
		CFG_GRID_COLUMNS,
		CFG_GRID_ROWS,
		CFG_LINE_HEIGHT
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] ink_cutoff;
		logic [3:0] cell_width_log2;
		logic [3:0] cell_height_log2;
		logic [4:0] grid_columns;
		logic [4:0] grid_rows;
		logic [7:0] line_pitch;
	} cfg_t;

	// one classified request waiting for the cell store
	typedef struct packed {
		logic             kind;
		logic             in_range;
		logic [BYTE_W-1:0] lx;
		logic [BYTE_W-1:0] ly;
		logic [BYTE_W-1:0] sel;
	} entry_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_UPDATE
	} back_state_t;

endpackage

// ----- hw/rtl/grid_cell_bounding_box.sv -----
// channel  | signals                                      | handshake
// request  | kind pixel_x pixel_y alpha cell_select       | req_valid / req_stall
// response | cell_number occupied box_* line_value        | rsp_valid / rsp_stall
// config   | cfg_index cfg_data                           | cfg_valid / cfg_ready
//
// a kept request (ink pixel inside the grid, or any read) goes through the back-end
// states BK_IDLE, which reads the cell store, and BK_UPDATE, which merges a pixel or
// clears an in-range read cell and writes it back; pixels dropped in the front end
// never reach the store; after reset a clearing pass writes every cell,
// with req_stall high; config writes are taken at any time (cfg_ready is always high)
// a two-entry queue separates the front end from the back end; rsp_stall holds the
// response register and backs up through the queue into req_stall
module grid_cell_bounding_box #(
	parameter int MAX_COLUMNS = 16,
	parameter int MAX_ROWS    = 16,
	parameter int COORD_BITS  = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gcbb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gcbb_pkg::BYTE_W-1:0]         cfg_data,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                kind,
	input  logic [gcbb_pkg::COORD_W-1:0]        pixel_x,
	input  logic [gcbb_pkg::COORD_W-1:0]        pixel_y,
	input  logic [gcbb_pkg::BYTE_W-1:0]         alpha,
	input  logic [gcbb_pkg::BYTE_W-1:0]         cell_select,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [gcbb_pkg::BYTE_W-1:0]         cell_number,
	output logic                                occupied,
	output logic [gcbb_pkg::BYTE_W-1:0]         box_left,
	output logic [gcbb_pkg::BYTE_W-1:0]         box_right,
	output logic [gcbb_pkg::BYTE_W-1:0]         box_top,
	output logic [gcbb_pkg::BYTE_W-1:0]         box_bottom,
	output logic [gcbb_pkg::BYTE_W-1:0]         line_value
);
	import gcbb_pkg::*;

	localparam int NUM_CELLS = MAX_COLUMNS * MAX_ROWS;
	localparam int CELL_BITS = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

	cfg_t                 cfg_q;
	logic                 clearing, q_full, push, pop, q_valid;
	entry_t               push_entry, q_entry;
	logic [CELL_BITS-1:0] push_addr, q_addr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ink_cutoff       <= RST_ALPHA_THRESHOLD;
			cfg_q.cell_width_log2  <= RST_CELL_WIDTH_LOG2;
			cfg_q.cell_height_log2 <= RST_CELL_HEIGHT_LOG2;
			cfg_q.grid_columns     <= RST_GRID_COLUMNS;
			cfg_q.grid_rows        <= RST_GRID_ROWS;
			cfg_q.line_pitch       <= RST_LINE_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_ALPHA_THRESHOLD:  cfg_q.ink_cutoff       <= cfg_data;
				CFG_CELL_WIDTH_LOG2:  cfg_q.cell_width_log2  <= cfg_data[3:0];
				CFG_CELL_HEIGHT_LOG2: cfg_q.cell_height_log2 <= cfg_data[3:0];
				CFG_GRID_COLUMNS:     cfg_q.grid_columns     <= cfg_data[4:0];
				CFG_GRID_ROWS:        cfg_q.grid_rows        <= cfg_data[4:0];
				CFG_LINE_HEIGHT:      cfg_q.line_pitch       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gcbb_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.COORD_BITS  (COORD_BITS),
		.CELL_BITS   (CELL_BITS)
	) u_front (
		.cfg         (cfg_q),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.alpha       (alpha),
		.cell_select (cell_select),
		.clearing    (clearing),
		.q_full      (q_full),
		.push        (push),
		.push_entry  (push_entry),
		.push_addr   (push_addr)
	);

	gcbb_queue #(
		.ADDR_W (CELL_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_addr  (push_addr),
		.full       (q_full),
		.pop        (pop),
		.head_valid (q_valid),
		.head_entry (q_entry),
		.head_addr  (q_addr)
	);

	gcbb_back #(
		.NUM_CELLS (NUM_CELLS),
		.CELL_BITS (CELL_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.clearing    (clearing),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_addr      (q_addr),
		.pop         (pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.cell_number (cell_number),
		.occupied    (occupied),
		.box_left    (box_left),
		.box_right   (box_right),
		.box_top     (box_top),
		.box_bottom  (box_bottom),
		.line_value  (line_value)
	);

endmodule

// ----- hw/rtl/gcbb_ram.sv -----
module gcbb_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/gcbb_front.sv -----
module gcbb_front #(
	parameter int MAX_COLUMNS = 16,
	parameter int MAX_ROWS    = 16,
	parameter int COORD_BITS  = 12,
	parameter int CELL_BITS   = 8
) (
	input  gcbb_pkg::cfg_t                      cfg,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                kind,
	input  logic [gcbb_pkg::COORD_W-1:0]        pixel_x,
	input  logic [gcbb_pkg::COORD_W-1:0]        pixel_y,
	input  logic [gcbb_pkg::BYTE_W-1:0]         alpha,
	input  logic [gcbb_pkg::BYTE_W-1:0]         cell_select,
	input  logic                                clearing,
	input  logic                                q_full,
	output logic                                push,
	output gcbb_pkg::entry_t                    push_entry,
	output logic [CELL_BITS-1:0]                push_addr
);
	import gcbb_pkg::*;

	localparam int NUM_CELLS = MAX_COLUMNS * MAX_ROWS;
	localparam int EXT_W     = ((CELL_BITS > BYTE_W) ? CELL_BITS : BYTE_W) + 1;
	localparam int CB        = (COORD_BITS > COORD_W) ? COORD_W : COORD_BITS;
	localparam logic [COORD_W-1:0] CMASK = COORD_W'((64'd1 << CB) - 64'd1);

	logic [COORD_W-1:0] x, y, col, row, cols_eff, rows_eff;
	logic [3:0]         wl, hl;
	logic [BYTE_W-1:0]  mx, my;
	logic               ink, in_grid, keep;
	logic [EXT_W-1:0]   sel_ext;
	logic [CELL_BITS-1:0] pix_idx;

	assign x  = pixel_x & CMASK;
	assign y  = pixel_y & CMASK;
	assign wl = (cfg.cell_width_log2 > LOG2_MAX) ? LOG2_MAX : cfg.cell_width_log2;
	assign hl = (cfg.cell_height_log2 > LOG2_MAX) ? LOG2_MAX : cfg.cell_height_log2;
	assign mx = BYTE_W'((9'd1 << wl) - 9'd1);
	assign my = BYTE_W'((9'd1 << hl) - 9'd1);
	assign col = x >> wl;
	assign row = y >> hl;

	assign cols_eff = (32'(cfg.grid_columns) > MAX_COLUMNS) ? COORD_W'(MAX_COLUMNS)
		: COORD_W'(cfg.grid_columns);
	assign rows_eff = (32'(cfg.grid_rows) > MAX_ROWS) ? COORD_W'(MAX_ROWS)
		: COORD_W'(cfg.grid_rows);

	assign in_grid = (col < cols_eff) && (row < rows_eff);
	assign ink     = alpha > cfg.ink_cutoff;
	assign pix_idx = CELL_BITS'(32'(row) * 32'(MAX_COLUMNS) + 32'(col));
	assign sel_ext = EXT_W'(cell_select);

	assign keep      = (kind == KIND_READ) || (in_grid && ink);
	assign req_stall = clearing || q_full;
	assign push      = req_valid && !req_stall && keep;

	always_comb begin
		push_entry.kind     = kind;
		push_entry.in_range = (kind == KIND_PIXEL) || (sel_ext < EXT_W'(NUM_CELLS));
		push_entry.lx       = x[BYTE_W-1:0] & mx;
		push_entry.ly       = y[BYTE_W-1:0] & my;
		push_entry.sel      = cell_select;
		push_addr = (kind == KIND_READ) ? sel_ext[CELL_BITS-1:0] : pix_idx;
	end

endmodule

// ----- hw/rtl/gcbb_queue.sv -----
module gcbb_queue #(
	parameter int ADDR_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  gcbb_pkg::entry_t      push_entry,
	input  logic [ADDR_W-1:0]     push_addr,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output gcbb_pkg::entry_t      head_entry,
	output logic [ADDR_W-1:0]     head_addr
);
	import gcbb_pkg::*;

	localparam int DEPTH = 2;

	entry_t            entry_q [DEPTH];
	logic [ADDR_W-1:0] addr_q  [DEPTH];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        count_q;

	assign full       = count_q == 2'(DEPTH);
	assign head_valid = count_q != 2'd0;
	assign head_entry = entry_q[rd_ptr_q];
	assign head_addr  = addr_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
			addr_q[wr_ptr_q]  <= push_addr;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue push while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("queue pop while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && !full) |=> head_valid)
		else $error("queue lost a request");

endmodule

// ----- hw/rtl/gcbb_back.sv -----
module gcbb_back #(
	parameter int NUM_CELLS = 256,
	parameter int CELL_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gcbb_pkg::cfg_t                cfg,
	output logic                          clearing,
	input  logic                          q_valid,
	input  gcbb_pkg::entry_t              q_entry,
	input  logic [CELL_BITS-1:0]          q_addr,
	output logic                          pop,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [gcbb_pkg::BYTE_W-1:0]   cell_number,
	output logic                          occupied,
	output logic [gcbb_pkg::BYTE_W-1:0]   box_left,
	output logic [gcbb_pkg::BYTE_W-1:0]   box_right,
	output logic [gcbb_pkg::BYTE_W-1:0]   box_top,
	output logic [gcbb_pkg::BYTE_W-1:0]   box_bottom,
	output logic [gcbb_pkg::BYTE_W-1:0]   line_value
);
	import gcbb_pkg::*;

	localparam logic [CELL_BITS-1:0] LAST_CELL = CELL_BITS'(NUM_CELLS - 1);

	back_state_t          state_q, state_d;
	logic [CELL_BITS-1:0] clr_cnt_q, clr_cnt_d;
	entry_t               item_q;
	logic [CELL_BITS-1:0] item_addr_q;

	logic                 ram_we, ram_re;
	logic [CELL_BITS-1:0] ram_waddr;
	logic [RAM_W-1:0]     ram_wdata, ram_rdata;

	logic                 rd_valid, out_free, load;
	logic [BYTE_W-1:0]    l_old, r_old, t_old, b_old;
	logic [BYTE_W-1:0]    l_new, r_new, t_new, b_new;
	logic [3:0]           hl;
	logic [9:0]           h, h3;
	logic [BYTE_W-1:0]    line_now;

	logic                 out_valid_q;
	logic [BYTE_W-1:0]    cell_number_q, left_q, right_q, top_q, bottom_q, line_q;
	logic                 occupied_q;

	gcbb_ram #(
		.WIDTH (RAM_W),
		.DEPTH (NUM_CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (q_addr),
		.rdata (ram_rdata)
	);

	// stored word: valid, bottom, top, right, left
	assign rd_valid = ram_rdata[BOX_W];
	assign l_old = ram_rdata[BYTE_W-1:0];
	assign r_old = ram_rdata[2*BYTE_W-1:BYTE_W];
	assign t_old = ram_rdata[3*BYTE_W-1:2*BYTE_W];
	assign b_old = ram_rdata[4*BYTE_W-1:3*BYTE_W];

	assign l_new = (!rd_valid || item_q.lx < l_old) ? item_q.lx : l_old;
	assign r_new = (!rd_valid || item_q.lx > r_old) ? item_q.lx : r_old;
	assign t_new = (!rd_valid || item_q.ly < t_old) ? item_q.ly : t_old;
	assign b_new = (!rd_valid || item_q.ly > b_old) ? item_q.ly : b_old;

	// zero line height selects three quarters of the cell height
	assign hl       = (cfg.cell_height_log2 > LOG2_MAX) ? LOG2_MAX : cfg.cell_height_log2;
	assign h        = 10'd1 << hl;
	assign h3       = (h << 1) + h;
	assign line_now = (cfg.line_pitch != '0) ? cfg.line_pitch : BYTE_W'(h3 >> 2);

	assign out_free = !out_valid_q || !rsp_stall;
	assign clearing = state_q == BK_CLEAR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			clr_cnt_q <= clr_cnt_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		clr_cnt_d = clr_cnt_q;
		ram_we    = 1'b0;
		ram_waddr = item_addr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		pop       = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				if (clr_cnt_q == LAST_CELL) begin
					state_d = BK_IDLE;
				end else begin
					clr_cnt_d = clr_cnt_q + 1'b1;
				end
			end
			BK_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					ram_re  = 1'b1;
					state_d = BK_UPDATE;
				end
			end
			BK_UPDATE: begin
				if (item_q.kind == KIND_PIXEL) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b1, b_new, t_new, r_new, l_new};
					state_d   = BK_IDLE;
				end else if (out_free) begin
					load    = 1'b1;
					ram_we  = item_q.in_range;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q      <= q_entry;
			item_addr_q <= q_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cell_number_q <= item_q.sel;
			occupied_q    <= item_q.in_range && rd_valid;
			left_q   <= (item_q.in_range && rd_valid) ? l_old : '0;
			right_q  <= (item_q.in_range && rd_valid) ? r_old : '0;
			top_q    <= (item_q.in_range && rd_valid) ? t_old : '0;
			bottom_q <= (item_q.in_range && rd_valid) ? b_old : '0;
			line_q   <= line_now;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign cell_number = cell_number_q;
	assign occupied    = occupied_q;
	assign box_left    = left_q;
	assign box_right   = right_q;
	assign box_top     = top_q;
	assign box_bottom  = bottom_q;
	assign line_value  = line_q;

	assert property (@(posedge clk) disable iff (!arst_n) clearing |-> !pop)
		else $error("request taken during clearing pass");
	assert property (@(posedge clk) disable iff (!arst_n) !(ram_we && ram_re))
		else $error("cell store read and written in one cycle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(clearing && clr_cnt_q != LAST_CELL) |=> clearing)
		else $error("clearing pass ended early");
	assert property (@(posedge clk) disable iff (!arst_n) load |=> rsp_valid)
		else $error("response not presented");

endmodule

// ----- tb/sv/grid_cell_bounding_box_tb.sv -----
module grid_cell_bounding_box_tb;
	import gcbb_pkg::*;

	localparam int COLS_MAX = 16;
	localparam int ROWS_MAX = 16;
	localparam int CELLS = COLS_MAX * ROWS_MAX;
	localparam int TARGET_ITEMS = 1550;
	localparam int SETTLE_CYCLES = 16;
	localparam int IDLE_LIMIT = 3000;

	typedef struct packed {
		logic [7:0] cell_number;
		logic       occupied;
		logic [7:0] box_left;
		logic [7:0] box_right;
		logic [7:0] box_top;
		logic [7:0] box_bottom;
		logic [7:0] line_value;
	} cell_report_t;

	typedef struct packed {
		logic [7:0] lo_x;
		logic [7:0] hi_x;
		logic [7:0] lo_y;
		logic [7:0] hi_y;
	} extent_t;

	typedef enum {
		STALL_NONE,
		STALL_COIN,
		STALL_PERIODIC,
		STALL_SPARSE
	} stall_mode_t;

	class cell_box_tracker;
		cfg_t         settings;
		bit           inked[CELLS];
		extent_t      extents[CELLS];
		cell_report_t pending_reports[$];
		int           errors;
		int           reports_checked;
		int           ink_pixels;
		int           reads;
		int           requests;

		function new();
			settings = '{RST_ALPHA_THRESHOLD, RST_CELL_WIDTH_LOG2, RST_CELL_HEIGHT_LOG2,
				RST_GRID_COLUMNS, RST_GRID_ROWS, RST_LINE_HEIGHT};
			foreach (inked[i]) begin
				inked[i] = 1'b0;
				extents[i] = '0;
			end
			errors = 0;
			reports_checked = 0;
			ink_pixels = 0;
			reads = 0;
			requests = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
			case (cfg_index_t'(idx))
				CFG_ALPHA_THRESHOLD:  settings.ink_cutoff = data;
				CFG_CELL_WIDTH_LOG2:  settings.cell_width_log2 = data[3:0];
				CFG_CELL_HEIGHT_LOG2: settings.cell_height_log2 = data[3:0];
				CFG_GRID_COLUMNS:     settings.grid_columns = data[4:0];
				CFG_GRID_ROWS:        settings.grid_rows = data[4:0];
				CFG_LINE_HEIGHT:      settings.line_pitch = data;
				default: ;
			endcase
		endfunction

		function int clamp_log2(logic [3:0] v);
			return (v > LOG2_MAX) ? int'(LOG2_MAX) : int'(v);
		endfunction

		function logic [7:0] line_now();
			int hl;
			if (settings.line_pitch != 0)
				return settings.line_pitch;
			hl = clamp_log2(settings.cell_height_log2);
			return 8'((3 * (1 << hl)) / 4);
		endfunction

		function void take_request(logic k, logic [11:0] x, logic [11:0] y, logic [7:0] a,
				logic [7:0] sel);
			int wl, hl, cols, rows, col, row, idx;
			logic [7:0] lx, ly;
			cell_report_t rep;
			requests++;
			if (k == KIND_READ) begin
				reads++;
				rep.cell_number = sel;
				rep.occupied = inked[sel];
				rep.box_left = inked[sel] ? extents[sel].lo_x : 8'd0;
				rep.box_right = inked[sel] ? extents[sel].hi_x : 8'd0;
				rep.box_top = inked[sel] ? extents[sel].lo_y : 8'd0;
				rep.box_bottom = inked[sel] ? extents[sel].hi_y : 8'd0;
				rep.line_value = line_now();
				inked[sel] = 1'b0;
				extents[sel] = '0;
				pending_reports.push_back(rep);
				return;
			end
			wl = clamp_log2(settings.cell_width_log2);
			hl = clamp_log2(settings.cell_height_log2);
			cols = (settings.grid_columns > COLS_MAX) ? COLS_MAX : int'(settings.grid_columns);
			rows = (settings.grid_rows > ROWS_MAX) ? ROWS_MAX : int'(settings.grid_rows);
			col = int'(x) >> wl;
			row = int'(y) >> hl;
			lx = 8'(int'(x) & ((1 << wl) - 1));
			ly = 8'(int'(y) & ((1 << hl) - 1));
			if (col >= cols || row >= rows || a <= settings.ink_cutoff)
				return;
			idx = row * COLS_MAX + col;
			ink_pixels++;
			if (!inked[idx]) begin
				extents[idx] = '{lx, lx, ly, ly};
			end else begin
				if (lx < extents[idx].lo_x) extents[idx].lo_x = lx;
				if (lx > extents[idx].hi_x) extents[idx].hi_x = lx;
				if (ly < extents[idx].lo_y) extents[idx].lo_y = ly;
				if (ly > extents[idx].hi_y) extents[idx].hi_y = ly;
			end
			inked[idx] = 1'b1;
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_response(cell_report_t got);
			cell_report_t want;
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: response for cell %0d with no request waiting, expected none",
					$time, got.cell_number);
				return;
			end
			want = pending_reports.pop_front();
			reports_checked++;
			compare_field("cell_number", want.cell_number, got.cell_number);
			compare_field("occupied", 8'(want.occupied), 8'(got.occupied));
			compare_field("box_left", want.box_left, got.box_left);
			compare_field("box_right", want.box_right, got.box_right);
			compare_field("box_top", want.box_top, got.box_top);
			compare_field("box_bottom", want.box_bottom, got.box_bottom);
			compare_field("line_value", want.line_value, got.line_value);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_index_t  cfg_index = CFG_ALPHA_THRESHOLD;
	logic [7:0]  cfg_data = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        kind = KIND_PIXEL;
	logic [11:0] pixel_x = '0;
	logic [11:0] pixel_y = '0;
	logic [7:0]  alpha = '0;
	logic [7:0]  cell_select = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [7:0]  cell_number;
	logic        occupied;
	logic [7:0]  box_left;
	logic [7:0]  box_right;
	logic [7:0]  box_top;
	logic [7:0]  box_bottom;
	logic [7:0]  line_value;

	cell_box_tracker boxes;
	int          burst_left = 0;
	bit          quiet = 1'b0;
	int          hot_col = 0;
	int          hot_row = 0;
	int          idle_cycles = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_run = 0;
	int          stall_tick = 0;

	grid_cell_bounding_box #(
		.MAX_COLUMNS(COLS_MAX),
		.MAX_ROWS   (ROWS_MAX),
		.COORD_BITS (COORD_W)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.kind       (kind),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.alpha      (alpha),
		.cell_select(cell_select),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.cell_number(cell_number),
		.occupied   (occupied),
		.box_left   (box_left),
		.box_right  (box_right),
		.box_top    (box_top),
		.box_bottom (box_bottom),
		.line_value (line_value)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_run = $urandom_range(16, 200);
		end
		stall_run--;
		stall_tick++;
		case (stall_mode)
			STALL_NONE:     rsp_stall <= 1'b0;
			STALL_COIN:     rsp_stall <= 1'($urandom_range(0, 1));
			STALL_PERIODIC: rsp_stall <= (stall_tick % 5) < 3;
			default:        rsp_stall <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			boxes.write_register(cfg_index, cfg_data);
		if (arst_n && req_valid && !req_stall)
			boxes.take_request(kind, pixel_x, pixel_y, alpha, cell_select);
		if (arst_n && rsp_valid && !rsp_stall)
			boxes.check_response(cell_report_t'{cell_number, occupied, box_left, box_right,
				box_top, box_bottom, line_value});
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic push_request(input logic k, input logic [11:0] x, input logic [11:0] y,
			input logic [7:0] a, input logic [7:0] sel);
		int gap;
		if (burst_left == 0) begin
			gap = quiet ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		req_valid <= 1'b1;
		kind <= k;
		pixel_x <= x;
		pixel_y <= y;
		alpha <= a;
		cell_select <= sel;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic put_pixel(input logic [11:0] x, input logic [11:0] y, input logic [7:0] a);
		push_request(KIND_PIXEL, x, y, a, 8'($urandom));
	endtask

	task automatic read_cell(input logic [7:0] sel);
		push_request(KIND_READ, 12'($urandom), 12'($urandom), 8'($urandom), sel);
	endtask

	// hold requests until every read has answered and the back end is quiet
	task automatic settle();
		req_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (boxes.pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(input cfg_t s);
		cfg_index_t idx;
		logic [7:0] data;
		idx = idx.first();
		cfg_valid <= 1'b1;
		for (int i = 0; i < idx.num(); i++) begin
			case (idx)
				CFG_ALPHA_THRESHOLD:  data = s.ink_cutoff;
				CFG_CELL_WIDTH_LOG2:  data = {4'($urandom), s.cell_width_log2};
				CFG_CELL_HEIGHT_LOG2: data = {4'($urandom), s.cell_height_log2};
				CFG_GRID_COLUMNS:     data = {3'($urandom), s.grid_columns};
				CFG_GRID_ROWS:        data = {3'($urandom), s.grid_rows};
				default:              data = s.line_pitch;
			endcase
			cfg_index <= idx;
			cfg_data <= data;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			idx = idx.next();
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic cfg_t pick_settings();
		cfg_t s;
		case ($urandom_range(0, 5))
			0: s = '{RST_ALPHA_THRESHOLD, RST_CELL_WIDTH_LOG2, RST_CELL_HEIGHT_LOG2,
				RST_GRID_COLUMNS, RST_GRID_ROWS, RST_LINE_HEIGHT};
			1: begin
				s.ink_cutoff = 8'($urandom_range(0, 20));
				s.cell_width_log2 = 4'($urandom_range(8, 15));
				s.cell_height_log2 = 4'($urandom_range(8, 15));
				s.grid_columns = 5'($urandom_range(14, 31));
				s.grid_rows = 5'($urandom_range(14, 31));
				s.line_pitch = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
			end
			2, 3: begin
				s.ink_cutoff = 8'($urandom_range(0, 120));
				s.cell_width_log2 = 4'($urandom_range(0, 3));
				s.cell_height_log2 = 4'($urandom_range(0, 3));
				s.grid_columns = 5'($urandom_range(1, 4));
				s.grid_rows = 5'($urandom_range(1, 4));
				s.line_pitch = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd0;
			end
			default: begin
				s.ink_cutoff = 8'($urandom);
				s.cell_width_log2 = 4'($urandom);
				s.cell_height_log2 = 4'($urandom);
				s.grid_columns = 5'($urandom);
				s.grid_rows = 5'($urandom);
				s.line_pitch = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'd0;
			end
		endcase
		return s;
	endfunction

	task automatic random_item(input cfg_t s);
		int wl, hl, cols, rows, col, row, th;
		logic [11:0] x, y;
		logic [7:0] a;
		wl = (s.cell_width_log2 > LOG2_MAX) ? int'(LOG2_MAX) : int'(s.cell_width_log2);
		hl = (s.cell_height_log2 > LOG2_MAX) ? int'(LOG2_MAX) : int'(s.cell_height_log2);
		cols = (s.grid_columns > COLS_MAX) ? COLS_MAX : int'(s.grid_columns);
		rows = (s.grid_rows > ROWS_MAX) ? ROWS_MAX : int'(s.grid_rows);
		th = s.ink_cutoff;
		x = 12'($urandom);
		y = 12'($urandom);
		a = 8'($urandom);
		col = 0;
		row = 0;
		if (cols > 0 && rows > 0) begin
			if ($urandom_range(0, 1) == 0) begin
				col = hot_col % cols;
				row = hot_row % rows;
			end else begin
				col = $urandom_range(0, cols - 1);
				row = $urandom_range(0, rows - 1);
			end
		end
		if ($urandom_range(0, 99) < 30) begin
			if (cols > 0 && rows > 0 && $urandom_range(0, 4) != 0)
				read_cell(8'(row * COLS_MAX + col));
			else
				read_cell(8'($urandom));
		end else begin
			if (cols > 0 && rows > 0 && $urandom_range(0, 5) != 0) begin
				x = 12'((col << wl) | $urandom_range(0, (1 << wl) - 1));
				y = 12'((row << hl) | $urandom_range(0, (1 << hl) - 1));
			end
			case ($urandom_range(0, 5))
				0: a = 8'(th);
				1: a = (th < 255) ? 8'(th + 1) : 8'(th);
				2: ;
				default: if (th < 255) a = 8'($urandom_range(th + 1, 255));
			endcase
			put_pixel(x, y, a);
		end
	endtask

	initial begin
		int phases;
		cfg_t s;
		boxes = new();
		phases = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: 16x16 cells on a 16x16 grid
		put_pixel(12'd0, 12'd0, 8'd255);
		put_pixel(12'd15, 12'd15, 8'd51);
		put_pixel(12'd7, 12'd3, 8'd50);
		put_pixel(12'd4095, 12'd4095, 8'd255);
		put_pixel(12'd255, 12'd255, 8'd255);
		put_pixel(12'd240, 12'd0, 8'd255);
		put_pixel(12'd16, 12'd16, 8'd0);
		read_cell(8'd0);
		read_cell(8'd0);
		read_cell(8'd1);
		read_cell(8'd15);
		settle();

		// one-pixel cells on a single-cell grid, cell 255 now outside the grid
		write_settings('{8'd0, 4'd0, 4'd0, 5'd1, 5'd1, 8'd0});
		read_cell(8'd255);
		put_pixel(12'd0, 12'd0, 8'd1);
		put_pixel(12'd1, 12'd0, 8'd255);
		put_pixel(12'd0, 12'd0, 8'd0);
		read_cell(8'd0);
		settle();

		// nothing can pass the top threshold, oversized settings clamp
		write_settings('{8'd255, 4'd15, 4'd15, 5'd31, 5'd31, 8'd255});
		put_pixel(12'd4095, 12'd4095, 8'd255);
		put_pixel(12'd100, 12'd200, 8'd255);
		read_cell(8'd255);
		settle();

		write_settings('{8'd0, 4'd8, 4'd8, 5'd16, 5'd16, 8'd0});
		put_pixel(12'd4095, 12'd4095, 8'd255);
		put_pixel(12'd256, 12'd0, 8'd1);
		read_cell(8'd255);
		read_cell(8'd1);
		settle();

		// empty grid drops every pixel
		write_settings('{8'd50, 4'd4, 4'd4, 5'd0, 5'd16, 8'd0});
		put_pixel(12'd0, 12'd0, 8'd255);
		read_cell(8'd0);

		while (boxes.requests < TARGET_ITEMS) begin
			s = pick_settings();
			settle();
			write_settings(s);
			quiet = ($urandom_range(0, 3) == 0);
			hot_col = $urandom_range(0, COLS_MAX - 1);
			hot_row = $urandom_range(0, ROWS_MAX - 1);
			repeat ($urandom_range(60, 160)) random_item(s);
			phases++;
		end
		settle();

		$display("covered %0d random setting phases plus directed corner cases", phases);
		$display("checked %0d cell reads against %0d ink pixels taken",
			boxes.reports_checked, boxes.ink_pixels);
		if (boxes.errors == 0 && boxes.pending_reports.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/gcbb_pkg.sv
hw/rtl/gcbb_ram.sv
hw/rtl/gcbb_front.sv
hw/rtl/gcbb_queue.sv
hw/rtl/gcbb_back.sv
hw/rtl/grid_cell_bounding_box.sv
tb/sv/grid_cell_bounding_box_tb.sv
